// ===== sv/scpp_pkg.sv =====
package scpp_pkg;

	// table geometry
	localparam int SIZE_CLASSES     = 64;
	localparam int SLOTS_PER_BUCKET = 16;
	localparam int HEADER_WORDS     = 2;

	// derived widths
	localparam int ADDR_W      = 48;
	localparam int CLS_W       = $clog2(SIZE_CLASSES);
	localparam int SLOT_W      = $clog2(SLOTS_PER_BUCKET);
	localparam int BUMP_W      = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int STORE_DEPTH = SIZE_CLASSES * SLOTS_PER_BUCKET;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int LAST_SLOT   = SLOTS_PER_BUCKET - 1;

	// two-entry queues between the parts
	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// input action codes
	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_MISS      = 3'd1,
		ST_TOO_BIG   = 3'd2,
		ST_PRESENT   = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	// command kinds after classification
	typedef enum logic [2:0] {
		K_ALLOC,
		K_LOAD,
		K_CLEAR,
		K_TOO_BIG,
		K_NOP
	} kind_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BUMP,
		BK_ADDR
	} back_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [CLS_W-1:0]    cls;
		logic [SLOT_W-1:0]   slot;
		logic                slot_ok;
		logic [ADDR_W-1:0]   addr;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   addr;
	} res_t;

endpackage

// ===== sv/scpp_front.sv =====
module scpp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           action,
	input  logic [7:0]           size_class,
	input  logic [3:0]           slot,
	input  logic [47:0]          load_address,
	output logic                 cmd_valid,
	output scpp_pkg::cmd_t       cmd,
	input  logic                 cmd_pop
);

	scpp_pkg::cmd_t                 cls_cmd;
	logic                           too_big;
	logic                           accept;
	scpp_pkg::cmd_t                 fifo_q [scpp_pkg::Q_DEPTH];
	logic [scpp_pkg::Q_PW-1:0]      wr_ptr_q;
	logic [scpp_pkg::Q_PW-1:0]      rd_ptr_q;
	logic [scpp_pkg::Q_CW-1:0]      cnt_q;
	logic                           do_pop;

	// size bound shared by allocate and load
	assign too_big = (32'(size_class) + 32'(scpp_pkg::HEADER_WORDS))
		>= 32'(scpp_pkg::SIZE_CLASSES);

	// classify the incoming transaction
	always_comb begin
		cls_cmd.cls     = scpp_pkg::CLS_W'(size_class);
		cls_cmd.slot    = scpp_pkg::SLOT_W'(slot);
		cls_cmd.slot_ok = 32'(slot) < 32'(scpp_pkg::SLOTS_PER_BUCKET);
		cls_cmd.addr    = load_address;
		unique case (scpp_pkg::action_t'(action))
			scpp_pkg::ACT_ALLOC: begin
				cls_cmd.kind = too_big ? scpp_pkg::K_TOO_BIG : scpp_pkg::K_ALLOC;
			end
			scpp_pkg::ACT_LOAD: begin
				cls_cmd.kind = too_big ? scpp_pkg::K_TOO_BIG : scpp_pkg::K_LOAD;
			end
			scpp_pkg::ACT_CLEAR: begin
				cls_cmd.kind = scpp_pkg::K_CLEAR;
			end
			default: begin
				cls_cmd.kind = scpp_pkg::K_NOP;
			end
		endcase
	end

	assign full      = cnt_q == scpp_pkg::Q_CW'(scpp_pkg::Q_DEPTH);
	assign accept    = push && !full;
	assign cmd_valid = cnt_q != '0;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_ptr_q] <= cls_cmd;
		end
	end

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= scpp_pkg::Q_CW'(scpp_pkg::Q_DEPTH))
		else $error("command queue count beyond depth");

endmodule

// ===== sv/scpp_back.sv =====
module scpp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  scpp_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output scpp_pkg::res_t       res
);

	scpp_pkg::back_state_t                state_q;
	scpp_pkg::back_state_t                state_d;
	scpp_pkg::cmd_t                       cur_q;
	logic [scpp_pkg::SIZE_CLASSES-1:0]    valid_q;
	logic [scpp_pkg::SIZE_CLASSES-1:0]    bump_ok_q;
	logic [scpp_pkg::BUMP_W-1:0]          bump_mem [scpp_pkg::SIZE_CLASSES];
	logic [scpp_pkg::BUMP_W-1:0]          bump_rd_q;
	logic [scpp_pkg::ADDR_W-1:0]          store_mem [scpp_pkg::STORE_DEPTH];
	logic [scpp_pkg::ADDR_W-1:0]          store_rd_q;

	logic                                 start;
	logic [scpp_pkg::CLS_W-1:0]           cls;
	logic [scpp_pkg::BUMP_W-1:0]          bump_val;
	logic                                 exhausted;
	logic                                 bump_re;
	logic                                 bump_we;
	logic [scpp_pkg::BUMP_W-1:0]          bump_wdata;
	logic                                 store_re;
	logic                                 store_we;
	logic [scpp_pkg::SLOT_W-1:0]          store_off;
	logic [scpp_pkg::STORE_AW-1:0]        store_idx;
	logic                                 set_valid;
	logic                                 clr_valid;
	logic                                 set_bump_ok;
	logic                                 clear_all;

	assign start     = (state_q == scpp_pkg::BK_IDLE) && cmd_valid && !res_full;
	assign cls       = (state_q == scpp_pkg::BK_IDLE) ? cmd.cls : cur_q.cls;
	assign bump_val  = bump_ok_q[cls] ? bump_rd_q : '0;
	assign exhausted = bump_val >= scpp_pkg::BUMP_W'(scpp_pkg::SLOTS_PER_BUCKET);
	assign store_idx = (scpp_pkg::STORE_AW'(cls)
		* scpp_pkg::STORE_AW'(scpp_pkg::SLOTS_PER_BUCKET))
		+ scpp_pkg::STORE_AW'(store_off);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scpp_pkg::BK_IDLE: begin
				if (start && cmd.kind == scpp_pkg::K_ALLOC && valid_q[cls]) begin
					state_d = scpp_pkg::BK_BUMP;
				end
			end
			scpp_pkg::BK_BUMP: begin
				state_d = exhausted ? scpp_pkg::BK_IDLE : scpp_pkg::BK_ADDR;
			end
			scpp_pkg::BK_ADDR: begin
				state_d = scpp_pkg::BK_IDLE;
			end
			default: begin
				state_d = scpp_pkg::BK_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res.status  = scpp_pkg::ST_DONE;
		res.addr    = '0;
		bump_re     = 1'b0;
		bump_we     = 1'b0;
		bump_wdata  = '0;
		store_re    = 1'b0;
		store_we    = 1'b0;
		store_off   = cmd.slot;
		set_valid   = 1'b0;
		clr_valid   = 1'b0;
		set_bump_ok = 1'b0;
		clear_all   = 1'b0;
		unique case (state_q)
			scpp_pkg::BK_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						scpp_pkg::K_ALLOC: begin
							if (valid_q[cls]) begin
								bump_re = 1'b1;
							end else begin
								res_push   = 1'b1;
								res.status = scpp_pkg::ST_MISS;
							end
						end
						scpp_pkg::K_LOAD: begin
							res_push = 1'b1;
							if (valid_q[cls]) begin
								res.status = scpp_pkg::ST_PRESENT;
							end else if (cmd.slot_ok) begin
								store_we = 1'b1;
								if (cmd.slot == '0) begin
									bump_we     = 1'b1;
									set_bump_ok = 1'b1;
								end
								if (cmd.slot == scpp_pkg::SLOT_W'(scpp_pkg::LAST_SLOT)) begin
									set_valid = 1'b1;
								end
							end
						end
						scpp_pkg::K_CLEAR: begin
							res_push  = 1'b1;
							clear_all = 1'b1;
						end
						scpp_pkg::K_TOO_BIG: begin
							res_push   = 1'b1;
							res.status = scpp_pkg::ST_TOO_BIG;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			scpp_pkg::BK_BUMP: begin
				// exhausted bucket drops out, otherwise fetch the next address
				if (exhausted) begin
					clr_valid  = 1'b1;
					res_push   = 1'b1;
					res.status = scpp_pkg::ST_MISS;
				end else begin
					store_re    = 1'b1;
					store_off   = scpp_pkg::SLOT_W'(bump_val);
					bump_we     = 1'b1;
					bump_wdata  = scpp_pkg::BUMP_W'(bump_val + 1'b1);
					set_bump_ok = 1'b1;
				end
			end
			scpp_pkg::BK_ADDR: begin
				res_push = 1'b1;
				if (store_rd_q == '0) begin
					clr_valid  = 1'b1;
					res.status = scpp_pkg::ST_MISS;
				end else begin
					res.status = scpp_pkg::ST_ALLOCATED;
					res.addr   = store_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	// state and per-class flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scpp_pkg::BK_IDLE;
			valid_q   <= '0;
			bump_ok_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear_all) begin
				valid_q   <= '0;
				bump_ok_q <= '0;
			end else begin
				if (set_valid) begin
					valid_q[cls] <= 1'b1;
				end
				if (clr_valid) begin
					valid_q[cls] <= 1'b0;
				end
				if (set_bump_ok) begin
					bump_ok_q[cls] <= 1'b1;
				end
			end
		end
	end

	// held command for a multi-cycle allocate
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= cmd;
		end
	end

	// bump index memory
	always_ff @(posedge clk) begin
		if (bump_we) begin
			bump_mem[cls] <= bump_wdata;
		end
		if (bump_re) begin
			bump_rd_q <= bump_mem[cls];
		end
	end

	// address store memory
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_idx] <= cmd.addr;
		end
		if (store_re) begin
			store_rd_q <= store_mem[store_idx];
		end
	end

	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(store_we && store_re))
		else $error("address store read and write in one cycle");

	a_addr_after_bump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == scpp_pkg::BK_ADDR |-> $past(state_q) == scpp_pkg::BK_BUMP)
		else $error("address phase without bump phase");

	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		bump_we |-> bump_wdata <= scpp_pkg::BUMP_W'(scpp_pkg::SLOTS_PER_BUCKET))
		else $error("bump index written out of range");

endmodule

// ===== sv/scpp_res_q.sv =====
module scpp_res_q (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  scpp_pkg::res_t       res,
	output logic                 res_full,
	output logic                 empty,
	input  logic                 pop,
	output logic [2:0]           status,
	output logic [47:0]          block_address
);

	scpp_pkg::res_t                 fifo_q [scpp_pkg::Q_DEPTH];
	logic [scpp_pkg::Q_PW-1:0]      wr_ptr_q;
	logic [scpp_pkg::Q_PW-1:0]      rd_ptr_q;
	logic [scpp_pkg::Q_CW-1:0]      cnt_q;
	logic                           do_push;
	logic                           do_pop;
	scpp_pkg::res_t                 head;

	assign res_full      = cnt_q == scpp_pkg::Q_CW'(scpp_pkg::Q_DEPTH);
	assign empty         = cnt_q == '0;
	assign do_push       = res_push && !res_full;
	assign do_pop        = pop && !empty;
	assign head          = fifo_q[rd_ptr_q];
	assign status        = head.status;
	assign block_address = head.addr;

	// result storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result pushed into a full queue");

endmodule

// ===== sv/size_class_pointer_pool.sv =====
// path: a result passes the command queue, then the result queue, both registered; an
// allocate with a valid bucket also needs a bump index read, then an address read
// throughput: one transaction per cycle for load, clear and rejected items, while
// the result queue has room; an allocate that reaches the address store blocks new
// transactions until its serial bump-index and address-store reads are done
// reset: asynchronous, all buckets invalid and both queues empty, no clearing pass
module size_class_pointer_pool (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    action,
	input  logic [7:0]    size_class,
	input  logic [3:0]    slot,
	input  logic [47:0]   load_address,
	output logic          empty,
	input  logic          pop,
	output logic [2:0]    status,
	output logic [47:0]   block_address
);

	logic                 cmd_valid;
	logic                 cmd_pop;
	scpp_pkg::cmd_t       cmd;
	logic                 res_push;
	logic                 res_full;
	scpp_pkg::res_t       res;

	// accept and classify
	scpp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.size_class   (size_class),
		.slot         (slot),
		.load_address (load_address),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	// bucket tables and sequencer
	scpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	// result queue
	scpp_res_q u_res_q (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_push      (res_push),
		.res           (res),
		.res_full      (res_full),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.block_address (block_address)
	);

endmodule
